// File: src/ssc_pkg.sv
// ssc_pkg: shared widths, limits and types for the substring spectrum counter
// used by ssc_table, substring_spectrum_counter_top and ssc_checker; depends on nothing
`default_nettype none

package ssc_pkg;

    localparam int MAX_WINDOW  = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int KEY_W       = 64;
    localparam int KEY_BYTES   = KEY_W / 8;
    localparam int CNT_W       = 16;
    localparam int LEN_W       = 4;
    localparam int RUN_W       = $clog2(MAX_WINDOW + 1);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(3);
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_entry            wr_entry;
    } t_tbl_req;

endpackage

`default_nettype wire

// File: src/ssc_table.sv
// ssc_table: key/count storage, one write port and one registered read port
// depends on ssc_pkg for the entry and request types
`default_nettype none

module ssc_table import ssc_pkg::*; (
    input  wire logic     i_clk,
    input  wire t_tbl_req i_req,
    output t_entry        o_rd_entry
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_entry <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_entry = r_rd_entry;

endmodule

`default_nettype wire

// File: src/substring_spectrum_counter_top.sv
// substring_spectrum_counter_top: windowing, run tracking and hashed table lookup
// depends on ssc_pkg and ssc_table
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------------------------
//  in       | input     | i_in_valid / o_in_stall    | i_char_code, i_string_start
//  out      | output    | o_out_valid / i_out_stall  | o_counted, o_substring_key,
//           |           |                            | o_substring_count, o_table_full
//  cfg      | input     | i_cfg_wr_en                | i_cfg_wr_data (window_length)
//
// an item with no complete window goes from idle straight to emit; a counted item passes hash,
// then read and compare for each occupied slot probed, split in two by the registered read
// port of the table ram, until an empty slot takes an insert, the key matches, or all
// TABLE_DEPTH slots are probed and the table is full
// one item at a time; the next request is taken while a result waits in the output register
// reset and string_start clear the slot valid flags at once, no clearing pass
// a stalled output only holds the last result; the block stalls its input at emit time
`default_nettype none

module substring_spectrum_counter_top import ssc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [7:0]        i_char_code,
    input  wire logic              i_string_start,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_counted,
    output logic [KEY_W-1:0]       o_substring_key,
    output logic [CNT_W-1:0]       o_substring_count,
    output logic                   o_table_full,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [LEN_W-1:0]  i_cfg_wr_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_READ,
        S_CMP,
        S_EMIT
    } t_state;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90) ||
               (c >= 8'd97 && c <= 8'd122);
    endfunction

    // xor fold with a per-chunk rotation so byte permutations spread out
    function automatic logic [ADDR_W-1:0] fold_key(input logic [KEY_W-1:0] key);
        logic [ADDR_W-1:0] h;
        h = '0;
        for (int i = 0; i < KEY_W; i++) begin
            h[(i + 3 * (i / ADDR_W)) % ADDR_W] ^= key[i];
        end
        return h;
    endfunction

    t_state                r_state, n_state;
    logic [LEN_W-1:0]      r_win_len, n_win_len;
    logic [KEY_W-1:0]      r_window, n_window;
    logic [RUN_W-1:0]      r_run, n_run;
    logic [KEY_W-1:0]      r_key, n_key;
    logic [ADDR_W-1:0]     r_addr, n_addr;
    logic [ADDR_W-1:0]     r_probes, n_probes;
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic                  r_res_counted, n_res_counted;
    logic [KEY_W-1:0]      r_res_key, n_res_key;
    logic [CNT_W-1:0]      r_res_count, n_res_count;
    logic                  r_res_full, n_res_full;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_counted, n_out_counted;
    logic [KEY_W-1:0]      r_out_key, n_out_key;
    logic [CNT_W-1:0]      r_out_count, n_out_count;
    logic                  r_out_full, n_out_full;

    logic [LEN_W-1:0]      w_len;
    logic [7:0]            w_char;
    logic [KEY_W-1:0]      w_win_base, w_win_next, w_key;
    logic [RUN_W-1:0]      w_run_base, w_run_next;
    logic                  w_counted;
    logic                  w_accept;
    logic [CNT_W-1:0]      w_inc_count;
    t_tbl_req              w_req;
    t_entry                w_rd_entry;

    ssc_table u_table (
        .i_clk      (i_clk),
        .i_req      (w_req),
        .o_rd_entry (w_rd_entry)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    // length 0 acts as 1, anything past the window size clamps to it
    always_comb begin
        if (r_win_len == '0) begin
            w_len = LEN_W'(1);
        end else if (r_win_len > LEN_W'(MAX_WINDOW)) begin
            w_len = LEN_W'(MAX_WINDOW);
        end else begin
            w_len = r_win_len;
        end
    end

    always_comb begin
        w_char = i_char_code;
        if (i_char_code >= 8'd65 && i_char_code <= 8'd90) begin
            w_char = i_char_code | 8'h20;
        end
        w_win_base = i_string_start ? '0 : r_window;
        w_win_next = {w_win_base[KEY_W-9:0], w_char};
        w_run_base = i_string_start ? '0 : r_run;
        if (!is_alnum(w_char)) begin
            w_run_next = '0;
        end else if (w_run_base < RUN_W'(MAX_WINDOW)) begin
            w_run_next = w_run_base + RUN_W'(1);
        end else begin
            w_run_next = w_run_base;
        end
        w_counted = (w_run_next >= RUN_W'(w_len));
        for (int b = 0; b < KEY_BYTES; b++) begin
            w_key[8*b +: 8] = (LEN_W'(b) < w_len) ? w_win_next[8*b +: 8] : 8'h00;
        end
    end

    assign w_inc_count = (w_rd_entry.count == CNT_MAX) ? w_rd_entry.count
                                                       : w_rd_entry.count + CNT_W'(1);

    always_comb begin
        n_state       = r_state;
        n_win_len     = r_win_len;
        n_window      = r_window;
        n_run         = r_run;
        n_key         = r_key;
        n_addr        = r_addr;
        n_probes      = r_probes;
        n_valid       = r_valid;
        n_res_counted = r_res_counted;
        n_res_key     = r_res_key;
        n_res_count   = r_res_count;
        n_res_full    = r_res_full;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_counted = r_out_counted;
        n_out_key     = r_out_key;
        n_out_count   = r_out_count;
        n_out_full    = r_out_full;

        w_req.rd_en          = 1'b0;
        w_req.rd_addr        = r_addr;
        w_req.wr_en          = 1'b0;
        w_req.wr_addr        = r_addr;
        w_req.wr_entry.key   = r_key;
        w_req.wr_entry.count = CNT_W'(1);

        if (i_cfg_wr_en) begin
            n_win_len = i_cfg_wr_data;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_window = w_win_next;
                    n_run    = w_run_next;
                    n_key    = w_key;
                    if (i_string_start) begin
                        n_valid = '0;
                    end
                    if (w_counted) begin
                        n_state = S_HASH;
                    end else begin
                        n_res_counted = 1'b0;
                        n_res_key     = '0;
                        n_res_count   = '0;
                        n_res_full    = 1'b0;
                        n_state       = S_EMIT;
                    end
                end
            end
            S_HASH: begin
                n_addr   = fold_key(r_key);
                n_probes = '0;
                n_state  = S_READ;
            end
            S_READ: begin
                if (!r_valid[r_addr]) begin
                    // empty slot ends the probe chain: insert here
                    w_req.wr_en     = 1'b1;
                    n_valid[r_addr] = 1'b1;
                    n_res_counted   = 1'b1;
                    n_res_key       = r_key;
                    n_res_count     = CNT_W'(1);
                    n_res_full      = 1'b0;
                    n_state         = S_EMIT;
                end else begin
                    w_req.rd_en = 1'b1;
                    n_state     = S_CMP;
                end
            end
            S_CMP: begin
                if (w_rd_entry.key == r_key) begin
                    w_req.wr_en          = 1'b1;
                    w_req.wr_entry.count = w_inc_count;
                    n_res_counted        = 1'b1;
                    n_res_key            = r_key;
                    n_res_count          = w_inc_count;
                    n_res_full           = 1'b0;
                    n_state              = S_EMIT;
                end else if (r_probes == ADDR_W'(TABLE_DEPTH - 1)) begin
                    // every slot probed and occupied by other keys
                    n_res_counted = 1'b0;
                    n_res_key     = r_key;
                    n_res_count   = '0;
                    n_res_full    = 1'b1;
                    n_state       = S_EMIT;
                end else begin
                    n_addr   = r_addr + ADDR_W'(1);
                    n_probes = r_probes + ADDR_W'(1);
                    n_state  = S_READ;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid   = 1'b1;
                    n_out_counted = r_res_counted;
                    n_out_key     = r_res_key;
                    n_out_count   = r_res_count;
                    n_out_full    = r_res_full;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win_len   <= LEN_RESET;
            r_window    <= '0;
            r_run       <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_win_len   <= n_win_len;
            r_window    <= n_window;
            r_run       <= n_run;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
        r_key         <= n_key;
        r_addr        <= n_addr;
        r_probes      <= n_probes;
        r_res_counted <= n_res_counted;
        r_res_key     <= n_res_key;
        r_res_count   <= n_res_count;
        r_res_full    <= n_res_full;
        r_out_counted <= n_out_counted;
        r_out_key     <= n_out_key;
        r_out_count   <= n_out_count;
        r_out_full    <= n_out_full;
    end

    assign o_out_valid       = r_out_valid;
    assign o_counted         = r_out_counted;
    assign o_substring_key   = r_out_key;
    assign o_substring_count = r_out_count;
    assign o_table_full      = r_out_full;

endmodule

`default_nettype wire

// File: src/ssc_checker.sv
// ssc_checker: port-level checks on substring_spectrum_counter_top, bound to it
// depends on ssc_pkg for widths
`default_nettype none

module ssc_checker import ssc_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic              o_counted,
    input wire logic [KEY_W-1:0]  o_substring_key,
    input wire logic [CNT_W-1:0]  o_substring_count,
    input wire logic              o_table_full
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_counted) &&
        $stable(o_substring_key) && $stable(o_substring_count) && $stable(o_table_full))
        else $error("stalled result changed");

    // one request at a time: a taken request stalls the input next cycle
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after request");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_counted && o_table_full))
        else $error("counted and table_full together");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_counted |-> o_substring_count != '0)
        else $error("counted result with zero count");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_counted && !o_table_full |->
        o_substring_key == '0 && o_substring_count == '0)
        else $error("uncounted result not zero");

endmodule

bind substring_spectrum_counter_top ssc_checker u_ssc_checker (.*);

`default_nettype wire
